// File: rtl/core/csmv_pkg.sv
// Shared types and constants for the CSR sparse matrix-vector (axpby) unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package csmv_pkg;

    // x vector store
    localparam int X_DEPTH = 1024;
    localparam int XA_W    = $clog2(X_DEPTH);

    // field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int ROW_W = 16;
    localparam int OP_W  = 2;
    localparam int ACC_W = 64;

    // stream payload widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 1'b1;
    localparam logic [VAL_W-1:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [VAL_W-1:0] BETA_RESET  = 32'h0000_0000;

    // result queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_NZ    = 2'd1,
        OP_EMPTY = 2'd2
    } t_op;

    // finished row sum handed from the accumulator to the scaler
    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] sum;
        logic             clip;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] y_old;
    } t_row_done;

    typedef struct packed {
        logic [VAL_W-1:0] y_new;
        logic [ROW_W-1:0] row;
        logic             sat;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/csmv_xstore.sv
// x vector store: single-port-write, single-read synchronous RAM with registered read data.
// Depends on csmv_pkg.
`default_nettype none

module csmv_xstore (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [csmv_pkg::XA_W-1:0]  i_wr_addr,
    input  wire logic [csmv_pkg::VAL_W-1:0] i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [csmv_pkg::XA_W-1:0]  i_rd_addr,
    output logic      [csmv_pkg::VAL_W-1:0] o_rd_data
);
    import csmv_pkg::*;

    logic [VAL_W-1:0] r_mem [X_DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/csmv_mac.sv
// Multiply-accumulate path: value * x product, saturating 64-bit row sum, row counter.
// Depends on csmv_pkg; x data comes from csmv_xstore in the cycle after the read.
`default_nettype none

module csmv_mac (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_acc,      // nonzero or empty-row beat taken
    input  wire logic                       i_nz,
    input  wire logic                       i_last,
    input  wire logic                       i_in_range,
    input  wire logic [csmv_pkg::VAL_W-1:0] i_value,
    input  wire logic [csmv_pkg::VAL_W-1:0] i_y_old,
    input  wire logic [csmv_pkg::VAL_W-1:0] i_x,
    output csmv_pkg::t_row_done             o_done,
    output logic      [1:0]                 o_pend      // row ends in flight here
);
    import csmv_pkg::*;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // stage 1: item waits for x read
    logic                    r_s1_valid;
    logic                    r_s1_nz;
    logic                    r_s1_fin;
    logic                    r_s1_inr;
    logic signed [VAL_W-1:0] r_s1_value;
    logic        [VAL_W-1:0] r_s1_yold;

    // stage 2: product ready
    logic                    r_s2_valid;
    logic                    r_s2_fin;
    logic signed [ACC_W-1:0] r_s2_prod;
    logic        [VAL_W-1:0] r_s2_yold;

    // accumulator state
    logic [ACC_W-1:0] r_row_sum;
    logic             r_sum_clipped;
    logic [ROW_W-1:0] r_row_ctr;

    // row handoff
    logic             r_d_valid;
    logic [ACC_W-1:0] r_d_sum;
    logic             r_d_clip;
    logic [ROW_W-1:0] r_d_row;
    logic [VAL_W-1:0] r_d_yold;

    logic signed [VAL_W-1:0] x_eff;
    logic signed [ACC_W-1:0] prod;
    logic        [ACC_W-1:0] sum_raw;
    logic                    ovf;
    logic        [ACC_W-1:0] n_sum;
    logic                    n_clip;

    // out-of-range column and empty rows contribute zero
    assign x_eff = (r_s1_nz && r_s1_inr) ? $signed(i_x) : '0;
    assign prod  = r_s1_value * x_eff;

    assign sum_raw = r_row_sum + r_s2_prod;
    assign ovf     = (r_row_sum[ACC_W-1] == r_s2_prod[ACC_W-1]) &&
                     (sum_raw[ACC_W-1] != r_row_sum[ACC_W-1]);
    assign n_sum   = ovf ? (r_row_sum[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum_raw;
    assign n_clip  = r_sum_clipped | ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_d_valid     <= 1'b0;
            r_row_sum     <= '0;
            r_sum_clipped <= 1'b0;
            r_row_ctr     <= '0;
        end else begin
            r_s1_valid <= i_acc;
            r_s2_valid <= r_s1_valid;
            r_d_valid  <= r_s2_valid & r_s2_fin;
            if (r_s2_valid) begin
                if (r_s2_fin) begin
                    r_row_sum     <= '0;
                    r_sum_clipped <= 1'b0;
                    r_row_ctr     <= r_row_ctr + 1'b1;
                end else begin
                    r_row_sum     <= n_sum;
                    r_sum_clipped <= n_clip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_nz    <= i_nz;
        r_s1_fin   <= ~i_nz | i_last;
        r_s1_inr   <= i_in_range;
        r_s1_value <= $signed(i_value);
        r_s1_yold  <= i_y_old;
        r_s2_fin   <= r_s1_fin;
        r_s2_prod  <= prod;
        r_s2_yold  <= r_s1_yold;
        r_d_sum    <= n_sum;
        r_d_clip   <= n_clip;
        r_d_row    <= r_row_ctr;
        r_d_yold   <= r_s2_yold;
    end

    assign o_done.valid = r_d_valid;
    assign o_done.sum   = r_d_sum;
    assign o_done.clip  = r_d_clip;
    assign o_done.row   = r_d_row;
    assign o_done.y_old = r_d_yold;

    assign o_pend = {1'b0, r_s1_valid & r_s1_fin} + {1'b0, r_s2_valid & r_s2_fin}
                  + {1'b0, r_d_valid};

endmodule

`default_nettype wire

// File: rtl/core/csmv_scale.sv
// Row scaler: alpha*sum + beta*y_old in partial products, round to Q16.16, saturate.
// Depends on csmv_pkg.
`default_nettype none

module csmv_scale (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  csmv_pkg::t_row_done             i_done,
    input  wire logic [csmv_pkg::VAL_W-1:0] i_alpha,
    input  wire logic [csmv_pkg::VAL_W-1:0] i_beta,
    output logic                            o_res_valid,
    output csmv_pkg::t_result               o_res
);
    import csmv_pkg::*;

    localparam int TW = 98;    // holds alpha*sum + beta*y_old<<16 exactly

    logic                    r_valid;
    logic signed [63:0]      r_ph;     // alpha * sum[63:32]
    logic signed [64:0]      r_pl;     // alpha * sum[31:0] (unsigned part)
    logic signed [63:0]      r_pb;     // beta * y_old
    logic                    r_clip;
    logic        [ROW_W-1:0] r_row;

    logic [TW-1:0] tot;
    logic [TW-1:0] half;
    logic [TW-64:0] top_bits;
    logic          fits;

    assign half = {{(TW-32){1'b0}}, 1'b1, 31'b0};
    assign tot  = {{(TW-96){r_ph[63]}}, r_ph, 32'b0}
                + {{(TW-65){r_pl[64]}}, r_pl}
                + {{(TW-80){r_pb[63]}}, r_pb, 16'b0}
                + half;

    assign top_bits = tot[TW-1:63];
    assign fits     = (&top_bits) | ~(|top_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph   <= $signed(i_done.sum[63:32]) * $signed(i_alpha);
        r_pl   <= $signed({1'b0, i_done.sum[31:0]}) * $signed(i_alpha);
        r_pb   <= $signed(i_done.y_old) * $signed(i_beta);
        r_clip <= i_done.clip;
        r_row  <= i_done.row;
    end

    assign o_res_valid = r_valid;
    assign o_res.y_new = fits ? tot[63:32]
                              : (tot[TW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign o_res.row   = r_row;
    assign o_res.sat   = r_clip | ~fits;

endmodule

`default_nettype wire

// File: rtl/core/csmv_outq.sv
// Result queue: small register FIFO between the scaler and the master stream port.
// Depends on csmv_pkg.
`default_nettype none

module csmv_outq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  csmv_pkg::t_result                  i_data,
    input  wire logic                          i_pop_ready,
    output logic                               o_valid,
    output csmv_pkg::t_result                  o_data,
    output logic      [csmv_pkg::OQ_CNT_W-1:0] o_cnt
);
    import csmv_pkg::*;

    t_result             r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                pop;

    assign pop = o_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_cnt   = r_cnt;

endmodule

`default_nettype wire

// File: rtl/core/csr_sparse_matvec_axpby_unit.sv
// Top level of the CSR sparse matrix-vector unit, y = alpha*A*x + beta*y.
// Depends on csmv_pkg, csmv_xstore, csmv_mac, csmv_scale, csmv_outq.
`default_nettype none

// Usage: load the dense vector x first with op LOAD beats (index = entry,
// value = Q16.16 data), then stream the matrix in CSR row order: op NZ beats
// carry a column index and a Q16.16 matrix value, tlast marks the last
// nonzero of a row, and op EMPTY closes a row that has no nonzeros. The beat
// that closes a row also carries that row's old y. Each closed row yields one
// master beat with y_new = alpha*sum + beta*y_old (Q16.16, rounded half up),
// the row number (from zero, wraps at 16 bits) and a saturation flag in tuser.
// Rate: one beat per clock while tready is high; the single 32x32 product per
// beat and the one read port of the x store set this. A closed row passes
// stage 1, stage 2, the row handoff register, the scaler registers and the
// result queue to the master side. Up to 8 finished rows (in flight plus
// queued) are held; slave tready is deasserted only when that budget is full.
// The x store has no reset; reading an entry never loaded gives undefined y.
// alpha/beta are written on the cfg channel (index 0 alpha, 1 beta); the user
// must do so only while idle (the block does not enforce it); cfg always ready.

module csr_sparse_matvec_axpby_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave stream: tdata = index[9:0], value[41:10], y_old[73:42], zero pad
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [csmv_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                           i_s_axis_tlast,    // last_in_row
    input  wire logic [csmv_pkg::S_TUSER_W-1:0] i_s_axis_tuser,    // op[1:0]
    // master stream: tdata = y_new[31:0], row_number[47:32]
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic      [csmv_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic      [csmv_pkg::M_TUSER_W-1:0] o_m_axis_tuser,    // saturated[0]
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [csmv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [csmv_pkg::VAL_W-1:0]     i_cfg_data
);
    import csmv_pkg::*;

    // gain registers
    logic [VAL_W-1:0] r_alpha;
    logic [VAL_W-1:0] r_beta;

    // slave beat fields
    t_op              s_op;
    logic [IDX_W-1:0] s_index;
    logic [VAL_W-1:0] s_value;
    logic [VAL_W-1:0] s_y_old;
    logic             s_take;
    logic             in_range;
    logic [XA_W-1:0]  x_addr;

    logic             do_load;
    logic             do_row;
    logic             is_nz;

    logic [VAL_W-1:0] x_data;
    t_row_done        done;
    logic [1:0]       mac_pend;
    logic             res_valid;
    t_result          res;
    t_result          q_data;
    logic [OQ_CNT_W-1:0] q_cnt;
    logic [OQ_CNT_W:0]   load_sum;

    assign s_op    = t_op'(i_s_axis_tuser[OP_W-1:0]);
    assign s_index = i_s_axis_tdata[IDX_W-1:0];
    assign s_value = i_s_axis_tdata[IDX_W +: VAL_W];
    assign s_y_old = i_s_axis_tdata[IDX_W+VAL_W +: VAL_W];
    assign s_take  = i_s_axis_tvalid & o_s_axis_tready;

    assign in_range = (32'(s_index) < 32'(X_DEPTH));
    assign x_addr   = XA_W'(s_index);

    // op decode; the unused op code does nothing
    always_comb begin
        is_nz  = 1'b0;
        do_row = 1'b0;
        case (s_op)
            OP_NZ: begin
                is_nz  = 1'b1;
                do_row = 1'b1;
            end
            OP_EMPTY: begin
                do_row = 1'b1;
            end
            default: begin
                is_nz  = 1'b0;
                do_row = 1'b0;
            end
        endcase
    end

    assign do_load = s_take & (s_op == OP_LOAD) & in_range;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_beta  <= BETA_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA: r_alpha <= i_cfg_data;
                CFG_BETA:  r_beta  <= i_cfg_data;
                default:   r_alpha <= r_alpha;
            endcase
        end
    end

    // x store: write on load, read for a nonzero; the data lands in stage 1
    csmv_xstore u_xstore (
        .i_clk     (i_clk),
        .i_wr_en   (do_load),
        .i_wr_addr (x_addr),
        .i_wr_data (s_value),
        .i_rd_en   (s_take & is_nz),
        .i_rd_addr (x_addr),
        .o_rd_data (x_data)
    );

    csmv_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (s_take & do_row),
        .i_nz       (is_nz),
        .i_last     (i_s_axis_tlast),
        .i_in_range (in_range),
        .i_value    (s_value),
        .i_y_old    (s_y_old),
        .i_x        (x_data),
        .o_done     (done),
        .o_pend     (mac_pend)
    );

    csmv_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_done      (done),
        .i_alpha     (r_alpha),
        .i_beta      (r_beta),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    csmv_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .i_pop_ready (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_data      (q_data),
        .o_cnt       (q_cnt)
    );

    // Room check: queued plus in-flight rows, plus the beat about to enter,
    // must fit the queue. Registered terms only, no path from m tready.
    assign load_sum = {1'b0, q_cnt} + (OQ_CNT_W+1)'(mac_pend)
                    + (OQ_CNT_W+1)'(res_valid);
    assign o_s_axis_tready = (load_sum < (OQ_CNT_W+1)'(OQ_DEPTH));

    assign o_m_axis_tdata = {q_data.row, q_data.y_new};
    assign o_m_axis_tuser = q_data.sat;

endmodule

`default_nettype wire

// File: rtl/core/csmv_chk.sv
// Port-level checker for csr_sparse_matvec_axpby_unit, attached with bind.
// Depends on csmv_pkg and the top level's port list.
`default_nettype none

module csmv_chk (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    input  wire logic                           o_s_axis_tready,
    input  wire logic                           i_s_axis_tlast,
    input  wire logic [csmv_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    input  wire logic                           o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [csmv_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  wire logic [csmv_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);
    import csmv_pkg::*;

    logic             s_fin;
    logic             m_take;
    logic [4:0]       r_pending;   // rows closed on the slave side, not yet out
    logic [ROW_W-1:0] r_exp_row;

    assign s_fin = i_s_axis_tvalid & o_s_axis_tready &
                   ((i_s_axis_tuser == OP_EMPTY) ||
                    ((i_s_axis_tuser == OP_NZ) && i_s_axis_tlast));
    assign m_take = o_m_axis_tvalid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_exp_row <= '0;
        end else begin
            r_pending <= r_pending + {4'b0, s_fin} - {4'b0, m_take};
            if (m_take) begin
                r_exp_row <= r_exp_row + 1'b1;
            end
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat shown right after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result beat changed");

    a_no_invented_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_pending != 5'd0)
        else $error("result beat with no closed row behind it");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[47:32] == r_exp_row)
        else $error("row number out of sequence");

    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending >= 5'd8 |-> !o_s_axis_tready)
        else $error("slave ready with result budget full");

endmodule

bind csr_sparse_matvec_axpby_unit csmv_chk u_csmv_chk (.*);

`default_nettype wire
